/* rtl/micro_op_datapath_8bit_macros.svh */
// Assertion macros used by the checker file of the micro-op datapath
`ifndef MICRO_OP_DATAPATH_8BIT_MACROS_SVH
`define MICRO_OP_DATAPATH_8BIT_MACROS_SVH

// same-cycle implication, masked during reset
`define MOPDP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mopdp assertion failed");

// next-cycle implication, masked during reset
`define MOPDP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mopdp assertion failed");

// next-cycle implication that also holds across reset
`define MOPDP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("mopdp assertion failed");

`endif

/* rtl/mopdp_pkg.sv */
// Types and constants of the micro-op datapath
package mopdp_pkg;

   localparam int DATA_W = 8;
   localparam int ADDR_W = 16;
   localparam int FUNC_W = 5;
   localparam int SEL_W  = 3;

   typedef enum logic [FUNC_W-1:0] {
      OP_PC_OUT   = 5'd0,
      OP_PC_IN    = 5'd1,
      OP_PCL_IN   = 5'd2,
      OP_PCH_IN   = 5'd3,
      OP_ALL_IN   = 5'd4,
      OP_ALH_IN   = 5'd5,
      OP_AL_IN    = 5'd6,
      OP_AA_OUT   = 5'd7,
      OP_DL_IN    = 5'd8,
      OP_DL_OUT   = 5'd9,
      OP_IR_IN    = 5'd10,
      OP_X_IN     = 5'd11,
      OP_Y_IN     = 5'd12,
      OP_ALU_OUT  = 5'd13,
      OP_ADD      = 5'd14,
      OP_SUB      = 5'd15,
      OP_INC      = 5'd16,
      OP_DEC      = 5'd17,
      OP_AND      = 5'd18,
      OP_NOT      = 5'd19,
      OP_SEL_REG  = 5'd20,
      OP_R_IN     = 5'd21,
      OP_R_OUT    = 5'd22,
      OP_READ     = 5'd23,
      OP_WRITE    = 5'd24,
      OP_WAIT_MEM = 5'd25,
      OP_FETCH    = 5'd26,
      OP_DRIVE    = 5'd27
   } op_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              zero;
      logic              carry;
   } alu_res_type;

   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

endpackage

/* rtl/mopdp_alu.sv */
// ALU of the micro-op datapath: add, sub, inc, dec with zero and carry flags; and, not
module mopdp_alu
   import mopdp_pkg::*;
(
   input  op_type            op,
   input  logic [DATA_W-1:0] x,
   input  logic [DATA_W-1:0] y,
   output alu_res_type       res
);

   logic [DATA_W:0] wide;

   always_comb begin
      wide = '0;
      res  = '0;
      unique case (op)
         OP_ADD: begin
            wide      = {1'b0, x} + {1'b0, y};
            res.value = wide[DATA_W-1:0];
            res.zero  = (wide[DATA_W-1:0] == '0);
            res.carry = wide[DATA_W];
         end
         OP_SUB: begin
            wide      = {1'b0, x} - {1'b0, y};
            res.value = wide[DATA_W-1:0];
            res.zero  = (wide[DATA_W-1:0] == '0);
            res.carry = wide[DATA_W];
         end
         OP_INC: begin
            wide      = {1'b0, x} + {{DATA_W{1'b0}}, 1'b1};
            res.value = wide[DATA_W-1:0];
            res.zero  = (wide[DATA_W-1:0] == '0);
            res.carry = wide[DATA_W];
         end
         OP_DEC: begin
            wide      = {1'b0, x} - {{DATA_W{1'b0}}, 1'b1};
            res.value = wide[DATA_W-1:0];
            res.zero  = (wide[DATA_W-1:0] == '0);
            res.carry = wide[DATA_W];
         end
         OP_AND: begin
            res.value = x & y;
         end
         OP_NOT: begin
            res.value = ~x;
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

/* rtl/mopdp_mem.sv */
// Byte memory of the micro-op datapath with registered read
module mopdp_mem
   import mopdp_pkg::*;
#(
   parameter int MEM_DEPTH = 65536
)
(
   input  logic              clock,
   input  logic              reset,
   input  mem_req_type       req,
   output logic [DATA_W-1:0] rdata
);

   localparam int AW = $clog2(MEM_DEPTH);

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic              oob_ff;
   logic              in_range;
   logic [AW-1:0]     idx;

   assign in_range = ({1'b0, req.addr} < (ADDR_W+1)'(MEM_DEPTH));
   assign idx      = req.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (req.wr && in_range) begin
         mem[idx] <= req.wdata;
      end
      if (req.rd) begin
         rdata_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oob_ff <= 1'b0;
      end else if (req.rd) begin
         oob_ff <= !in_range;
      end
   end

   assign rdata = oob_ff ? '0 : rdata_ff;

endmodule

/* rtl/micro_op_datapath_8bit.sv */
// Top level of the 8-bit micro-op datapath
//
//   channel  | ports                                         | dir
//   ---------+-----------------------------------------------+-----
//   req      | req_valid/ready, func, reg_num, bus_in        | in
//   rsp      | rsp_valid/ready, data_bus, addr_bus, flags,   | out
//            | instr_reg, prog_counter                       |
//
// One beat per cycle in and out unless stalled; a result goes through the result stage, then the output register.
// Read and fetch resolve through the memory's registered read port in the following cycle.
// Synchronous reset clears the datapath registers, the valid flags and the register file, not the output data.
// The output register holds a result until taken; req_ready drops only when
// both the result stage and the output register are full and rsp_ready is low.
module micro_op_datapath_8bit
   import mopdp_pkg::*;
#(
   parameter int NUM_REGS  = 8,
   parameter int MEM_DEPTH = 65536
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [SEL_W-1:0]  req_reg_num,
   input  logic [DATA_W-1:0] req_bus_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_data_bus,
   output logic [ADDR_W-1:0] rsp_addr_bus,
   output logic              rsp_zero_flag,
   output logic              rsp_carry_flag,
   output logic [DATA_W-1:0] rsp_instr_reg,
   output logic [ADDR_W-1:0] rsp_prog_counter
);

   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [ADDR_W-1:0] al_ff, al_in;
   logic [DATA_W-1:0] dl_ff, dl_in;
   logic [DATA_W-1:0] ir_ff, ir_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] y_ff, y_in;
   logic [DATA_W-1:0] alu_ff, alu_in;
   logic              zf_ff, zf_in;
   logic              cf_ff, cf_in;
   logic [SEL_W-1:0]  sel_ff, sel_in;
   logic [DATA_W-1:0] dbus_ff, dbus_in;
   logic [ADDR_W-1:0] abus_ff, abus_in;
   logic              pend_rd_ff, pend_rd_in;
   logic              pend_fetch_ff, pend_fetch_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] reg_file_ff [NUM_REGS];

   logic [DATA_W-1:0] rsp_dbus_ff;
   logic [ADDR_W-1:0] rsp_abus_ff;
   logic              rsp_zf_ff;
   logic              rsp_cf_ff;
   logic [DATA_W-1:0] rsp_ir_ff;
   logic [ADDR_W-1:0] rsp_pc_ff;

   logic              accept;
   logic              move;
   op_type            op;
   logic [RW-1:0]     ridx;
   logic              sel_ok;
   logic              rf_we;
   logic [DATA_W-1:0] rdata;
   logic [DATA_W-1:0] dl_eff;
   logic [DATA_W-1:0] dbus_eff;
   logic [DATA_W-1:0] ir_eff;
   alu_res_type       alu_res;
   mem_req_type       mem_req;

   assign op        = op_type'(req_func);
   assign move      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign ridx   = RW'(sel_ff);
   assign sel_ok = (int'(sel_ff) < NUM_REGS);

   // resolve values whose memory read returns this cycle
   assign dl_eff   = (pend_rd_ff || pend_fetch_ff) ? rdata : dl_ff;
   assign dbus_eff = pend_fetch_ff ? rdata : dbus_ff;
   assign ir_eff   = pend_fetch_ff ? rdata : ir_ff;

   mopdp_alu u_alu (
      .op  (op),
      .x   (x_ff),
      .y   (y_ff),
      .res (alu_res)
   );

   mopdp_mem #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .req   (mem_req),
      .rdata (rdata)
   );

   always_comb begin
      pc_in         = pc_ff;
      al_in         = al_ff;
      dl_in         = dl_eff;
      ir_in         = ir_eff;
      x_in          = x_ff;
      y_in          = y_ff;
      alu_in        = alu_ff;
      zf_in         = zf_ff;
      cf_in         = cf_ff;
      sel_in        = sel_ff;
      dbus_in       = dbus_eff;
      abus_in       = abus_ff;
      pend_rd_in    = 1'b0;
      pend_fetch_in = 1'b0;
      rf_we         = 1'b0;
      mem_req       = '0;
      if (accept) begin
         unique case (op)
            OP_PC_OUT:  abus_in = pc_ff;
            OP_PC_IN:   pc_in   = abus_ff;
            OP_PCL_IN:  pc_in   = {pc_ff[ADDR_W-1:DATA_W], dbus_eff};
            OP_PCH_IN:  pc_in   = {dbus_eff, pc_ff[DATA_W-1:0]};
            OP_ALL_IN:  al_in   = {al_ff[ADDR_W-1:DATA_W], dbus_eff};
            OP_ALH_IN:  al_in   = {dbus_eff, al_ff[DATA_W-1:0]};
            OP_AL_IN:   al_in   = abus_ff;
            OP_AA_OUT:  abus_in = al_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
            OP_DL_IN:   dl_in   = dbus_eff;
            OP_DL_OUT:  dbus_in = dl_eff;
            OP_IR_IN:   ir_in   = dbus_eff;
            OP_X_IN:    x_in    = dbus_eff;
            OP_Y_IN:    y_in    = dbus_eff;
            OP_ALU_OUT: dbus_in = alu_ff;
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_AND, OP_NOT: begin
               alu_in = alu_res.value;
               zf_in  = alu_res.zero;
               cf_in  = alu_res.carry;
            end
            OP_SEL_REG: sel_in  = req_reg_num;
            OP_R_IN:    rf_we   = sel_ok;
            OP_R_OUT:   dbus_in = sel_ok ? reg_file_ff[ridx] : '0;
            OP_READ: begin
               mem_req.rd   = 1'b1;
               mem_req.addr = al_ff;
               pend_rd_in   = 1'b1;
            end
            OP_WRITE: begin
               mem_req.wr    = 1'b1;
               mem_req.addr  = al_ff;
               mem_req.wdata = dl_eff;
            end
            OP_WAIT_MEM: begin
            end
            OP_FETCH: begin
               mem_req.rd    = 1'b1;
               mem_req.addr  = pc_ff;
               al_in         = pc_ff;
               abus_in       = pc_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
               pc_in         = pc_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
               pend_fetch_in = 1'b1;
            end
            OP_DRIVE:   dbus_in = req_bus_in;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= '0;
         al_ff         <= '0;
         dl_ff         <= '0;
         ir_ff         <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         alu_ff        <= '0;
         zf_ff         <= 1'b0;
         cf_ff         <= 1'b0;
         sel_ff        <= '0;
         dbus_ff       <= '0;
         abus_ff       <= '0;
         pend_rd_ff    <= 1'b0;
         pend_fetch_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         al_ff         <= al_in;
         dl_ff         <= dl_in;
         ir_ff         <= ir_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         alu_ff        <= alu_in;
         zf_ff         <= zf_in;
         cf_ff         <= cf_in;
         sel_ff        <= sel_in;
         dbus_ff       <= dbus_in;
         abus_ff       <= abus_in;
         pend_rd_ff    <= pend_rd_in;
         pend_fetch_ff <= pend_fetch_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            reg_file_ff[i] <= '0;
         end
      end else if (rf_we) begin
         reg_file_ff[ridx] <= dbus_eff;
      end
   end

   // snapshot the post-operation state into the output register
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_dbus_ff <= dbus_eff;
         rsp_abus_ff <= abus_ff;
         rsp_zf_ff   <= zf_ff;
         rsp_cf_ff   <= cf_ff;
         rsp_ir_ff   <= ir_eff;
         rsp_pc_ff   <= pc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_bus     = rsp_dbus_ff;
   assign rsp_addr_bus     = rsp_abus_ff;
   assign rsp_zero_flag    = rsp_zf_ff;
   assign rsp_carry_flag   = rsp_cf_ff;
   assign rsp_instr_reg    = rsp_ir_ff;
   assign rsp_prog_counter = rsp_pc_ff;

endmodule

/* rtl/mopdp_checker.sv */
// Port-level checker of the micro-op datapath and its bind
`include "micro_op_datapath_8bit_macros.svh"

module mopdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_data_bus,
   input logic [15:0] rsp_addr_bus,
   input logic        rsp_zero_flag,
   input logic        rsp_carry_flag,
   input logic [7:0]  rsp_instr_reg,
   input logic [15:0] rsp_prog_counter
);

   logic [49:0] rsp_payload;

   assign rsp_payload = {rsp_data_bus, rsp_addr_bus, rsp_zero_flag, rsp_carry_flag,
                         rsp_instr_reg, rsp_prog_counter};

   `MOPDP_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   `MOPDP_ASSERT_NEXT(a_beat_reaches_out, req_valid && req_ready, ##1 rsp_valid)

   `MOPDP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   `MOPDP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload))

endmodule

bind micro_op_datapath_8bit mopdp_checker u_mopdp_checker (.*);
